// ===== rtl/assert_macros.svh =====
// Assertion macros used by the interpolator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/trhi_pkg.sv =====
// Types, constants and helpers of the rate history interpolator.
package trhi_pkg;

  localparam logic FUNC_INGEST = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  localparam logic CFG_LATENCY = 1'b0;
  localparam logic CFG_MAX_GAP = 1'b1;

  localparam logic signed [33:0] PI_Q28     = 34'sd843314857;
  localparam logic signed [33:0] NEG_PI_Q28 = -34'sd843314857;
  localparam logic signed [33:0] TWO_PI_Q28 = 34'sd1686629713;

  localparam logic [63:0] DT_MIN_NS  = 64'd100000;
  localparam logic [63:0] DT_MAX_NS  = 64'd1000000000;
  localparam logic [63:0] MAX_AGE_NS = 64'd2000000000;
  localparam logic [29:0] GAP_FLOOR_NS = 30'd1000000;
  localparam logic [29:0] NS_PER_S     = 30'd1000000000;
  localparam logic [29:0] MAX_GAP_RESET = 30'd100000000;

  typedef struct packed {
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] roll;
    logic [63:0] ts;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ING_CHK,
    ST_ING_LOAD,
    ST_ING_WRAP,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ING_FIN,
    ST_ING_WR,
    ST_AGE_RD,
    ST_AGE_CHK,
    ST_ING_PREV,
    ST_LK_START,
    ST_LK_LAST,
    ST_LK_FIRST,
    ST_LK_WALK,
    ST_LK_GAP,
    ST_LK_FIN,
    ST_LK_OUT
  } state_t;

  function automatic logic [31:0] entry_rate(input entry_t e, input logic [1:0] ax);
    logic [31:0] r;
    case (ax)
      2'd0:    r = e.roll;
      2'd1:    r = e.pitch;
      default: r = e.yaw;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/trhi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module trhi_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/timestamped_rate_history_interp_core.sv =====
// Rate history ring with time-bracketed linear interpolation of body rates.
// Ingest: a sample that makes an entry runs three divisions of 64 quotient bits, one per axis,
//   writes the entry and drops aged-out ones; otherwise it updates or, when invalid, clears the previous sample.
// Lookup: walks the ring pair by pair until a pair brackets the query, then interpolates each axis
//   with the shared bit-serial divider (one quotient bit per cycle).
// One word at a time; a finished result waits in the output register.
// rst is synchronous: empty ring, no previous sample, registers at their reset values.
`include "assert_macros.svh"

module timestamped_rate_history_interp_core #(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  // in tuser: func
  input  logic         s_tvalid,
  output logic         s_tready,
  // in tdata: sample_valid, sample_time_ns, roll_angle, pitch_angle, yaw_angle,
  //   query_time_ns, zero pad
  input  logic [231:0] s_tdata,
  input  logic         s_tuser,
  // out tuser: rate_found
  output logic         m_tvalid,
  input  logic         m_tready,
  // out tdata: roll_omega, pitch_omega, yaw_omega, bracket_gap_ns
  output logic [127:0] m_tdata,
  output logic         m_tuser,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);
  import trhi_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);

  // input field views
  logic        in_valid;
  logic [63:0] in_time, in_query;
  logic [31:0] in_ang [3];
  assign in_valid  = s_tdata[0];
  assign in_time   = s_tdata[64:1];
  assign in_ang[0] = s_tdata[96:65];
  assign in_ang[1] = s_tdata[128:97];
  assign in_ang[2] = s_tdata[160:129];
  assign in_query  = s_tdata[224:161];

  // configuration
  logic [30:0] lat_off;
  logic [29:0] max_gap;
  logic [29:0] gap_limit;
  assign gap_limit = (max_gap < GAP_FLOOR_NS) ? GAP_FLOOR_NS : max_gap;

  // control and datapath registers
  state_t        state, state_next;
  logic          is_lk, is_lk_next;
  logic [1:0]    axis, axis_next;
  logic [1:0]    wcnt, wcnt_next;
  logic [5:0]    dcnt, dcnt_next;
  logic [63:0]   t_reg, t_next;
  logic [63:0]   q_reg, q_next;
  logic [31:0]   cur_ang [3];
  logic [31:0]   cur_ang_next [3];
  logic [29:0]   dt_reg, dt_next;
  logic signed [33:0] d_reg, d_next;
  logic          neg_reg, neg_next;
  logic [62:0]   prod_reg, prod_next;
  logic [63:0]   dvd, dvd_next;
  logic [64:0]   rem, rem_next;
  logic [63:0]   div_reg, div_next;
  logic [63:0]   half_reg, half_next;
  logic [31:0]   rate_reg [3];
  logic [31:0]   rate_next [3];
  logic          found_reg, found_next;
  logic [31:0]   gap_out, gap_out_next;
  logic [29:0]   gap_reg, gap_next;
  logic [29:0]   off_reg, off_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [AW-1:0] oldest, oldest_next;
  logic [CW-1:0] widx, widx_next;
  logic [63:0]   prev_time, prev_time_next;
  logic [31:0]   prev_ang [3];
  logic [31:0]   prev_ang_next [3];
  logic          prev_ok, prev_ok_next;
  entry_t        a_reg, a_next, b_reg, b_next;
  logic          m_tvalid_next;
  logic [127:0]  m_tdata_next;
  logic          m_tuser_next;

  // ring storage
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, rd;
  logic [$bits(entry_t)-1:0] ram_rdata;

  trhi_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
  assign rd = entry_t'(ram_rdata);

  // logical position -> physical slot, modulo depth
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] x);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(x);
    if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == AW'(HISTORY_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  // sign bit of one rate of an entry, for 33-bit differences
  function automatic logic b_reg_rate_sign(input entry_t e, input logic [1:0] ax);
    logic [31:0] r;
    r = entry_rate(e, ax);
    return r[31];
  endfunction

  // latency correction: positive offset floors at zero, negative saturates high
  logic [63:0] corr_t;
  logic [63:0] off_mag;
  logic [64:0] corr_sum;
  always_comb begin
    off_mag  = lat_off[30] ? {33'd0, (~lat_off + 31'd1)} : {33'd0, lat_off};
    corr_sum = {1'b0, in_time} + {1'b0, off_mag};
    if (!lat_off[30]) begin
      corr_t = (in_time > off_mag) ? in_time - off_mag : 64'd0;
    end else begin
      corr_t = corr_sum[64] ? '1 : corr_sum[63:0];
    end
  end

  // shared multiplier operands and divider step
  logic [32:0] mul_a;
  logic [29:0] mul_b;
  logic [64:0] trial;
  logic signed [32:0] lk_diff;
  logic signed [33:0] abs_d;
  logic [63:0] dt_full, age, gap_full;
  logic [31:0] q_sat, a_rate;

  always_comb begin
    state_next       = state;
    is_lk_next       = is_lk;
    axis_next        = axis;
    wcnt_next        = wcnt;
    dcnt_next        = dcnt;
    t_next           = t_reg;
    q_next           = q_reg;
    cur_ang_next     = cur_ang;
    dt_next          = dt_reg;
    d_next           = d_reg;
    neg_next         = neg_reg;
    prod_next        = prod_reg;
    dvd_next         = dvd;
    rem_next         = rem;
    div_next         = div_reg;
    half_next        = half_reg;
    rate_next        = rate_reg;
    found_next       = found_reg;
    gap_out_next     = gap_out;
    gap_next         = gap_reg;
    off_next         = off_reg;
    entry_count_next = entry_count;
    oldest_next      = oldest;
    widx_next        = widx;
    prev_time_next   = prev_time;
    prev_ang_next    = prev_ang;
    prev_ok_next     = prev_ok;
    a_next           = a_reg;
    b_next           = b_reg;
    m_tvalid_next    = m_tvalid & ~m_tready;
    m_tdata_next     = m_tdata;
    m_tuser_next     = m_tuser;
    ram_we           = 1'b0;
    ram_waddr        = slot(oldest, entry_count);
    ram_wdata        = '{yaw: rate_reg[2], pitch: rate_reg[1], roll: rate_reg[0], ts: t_reg};
    ram_raddr        = oldest;
    s_tready         = (state == ST_IDLE);
    mul_a            = '0;
    mul_b            = '0;
    trial            = {rem[63:0], dvd[63]};
    lk_diff          = $signed({b_reg_rate_sign(b_reg, axis), entry_rate(b_reg, axis)})
                     - $signed({b_reg_rate_sign(a_reg, axis), entry_rate(a_reg, axis)});
    abs_d            = d_reg[33] ? -d_reg : d_reg;
    dt_full          = t_reg - prev_time;
    age              = t_reg - rd.ts;
    gap_full         = b_reg.ts - a_reg.ts;
    q_sat            = '0;
    a_rate           = entry_rate(a_reg, axis);

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          q_next       = in_query;
          t_next       = corr_t;
          cur_ang_next = in_ang;
          if (s_tuser == FUNC_LOOKUP) begin
            is_lk_next = 1'b1;
            state_next = ST_LK_START;
          end else if (!in_valid || in_time == 64'd0) begin
            prev_ok_next = 1'b0;
          end else begin
            is_lk_next = 1'b0;
            state_next = ST_ING_CHK;
          end
        end
      end
      ST_ING_CHK: begin
        if (prev_ok && t_reg > prev_time && dt_full > DT_MIN_NS && dt_full < DT_MAX_NS) begin
          dt_next    = dt_full[29:0];
          axis_next  = 2'd0;
          state_next = ST_ING_LOAD;
        end else begin
          state_next = ST_ING_PREV;
        end
      end
      ST_ING_LOAD: begin
        d_next     = $signed({{2{cur_ang[axis][31]}}, cur_ang[axis]})
                   - $signed({{2{prev_ang[axis][31]}}, prev_ang[axis]});
        wcnt_next  = 2'd0;
        state_next = ST_ING_WRAP;
      end
      ST_ING_WRAP: begin
        // fold into [-pi, pi]; three corrections suffice for any 33-bit difference
        if (d_reg > PI_Q28) d_next = d_reg - TWO_PI_Q28;
        else if (d_reg < NEG_PI_Q28) d_next = d_reg + TWO_PI_Q28;
        wcnt_next = wcnt + 2'd1;
        if (wcnt == 2'd3) state_next = ST_MUL;
      end
      ST_MUL: begin
        if (is_lk) begin
          neg_next  = lk_diff[32];
          mul_a     = lk_diff[32] ? 33'(-lk_diff) : 33'(lk_diff);
          mul_b     = off_reg;
          div_next  = {34'd0, gap_reg};
          half_next = {35'd0, gap_reg[29:1]};
        end else begin
          neg_next  = d_reg[33];
          mul_a     = abs_d[32:0];
          mul_b     = NS_PER_S;
          div_next  = {22'd0, dt_reg, 12'd0};
          half_next = {23'd0, dt_reg, 11'd0};
        end
        prod_next  = {30'd0, mul_a} * {33'd0, mul_b};
        state_next = ST_DIV_LOAD;
      end
      ST_DIV_LOAD: begin
        dvd_next   = {1'b0, prod_reg} + half_reg;
        rem_next   = '0;
        dcnt_next  = 6'd0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle shifted into dvd
        if (trial >= {1'b0, div_reg}) begin
          rem_next = trial - {1'b0, div_reg};
          dvd_next = {dvd[62:0], 1'b1};
        end else begin
          rem_next = trial;
          dvd_next = {dvd[62:0], 1'b0};
        end
        dcnt_next = dcnt + 6'd1;
        if (dcnt == 6'd63) state_next = is_lk ? ST_LK_FIN : ST_ING_FIN;
      end
      ST_ING_FIN: begin
        if (neg_reg) begin
          q_sat = (dvd > 64'h8000_0000) ? 32'h8000_0000 : dvd[31:0];
          rate_next[axis] = 32'd0 - q_sat;
        end else begin
          rate_next[axis] = (dvd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dvd[31:0];
        end
        if (axis == 2'd2) begin
          state_next = ST_ING_WR;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_ING_LOAD;
        end
      end
      ST_ING_WR: begin
        ram_we = 1'b1;
        if (entry_count < CW'(HISTORY_DEPTH)) entry_count_next = entry_count + CW'(1);
        else oldest_next = next_slot(oldest);
        state_next = ST_AGE_RD;
      end
      ST_AGE_RD: begin
        ram_raddr  = oldest;
        state_next = (entry_count == '0) ? ST_ING_PREV : ST_AGE_CHK;
      end
      ST_AGE_CHK: begin
        // wrapping difference: entries stamped later than the newest drop too
        if (age > MAX_AGE_NS) begin
          oldest_next      = next_slot(oldest);
          entry_count_next = entry_count - CW'(1);
          state_next       = ST_AGE_RD;
        end else begin
          state_next = ST_ING_PREV;
        end
      end
      ST_ING_PREV: begin
        prev_time_next = t_reg;
        prev_ang_next  = cur_ang;
        prev_ok_next   = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_LK_START: begin
        found_next   = 1'b0;
        gap_out_next = '0;
        rate_next    = '{3{32'd0}};
        ram_raddr    = slot(oldest, entry_count - CW'(1));
        if (q_reg == 64'd0 || entry_count < CW'(2)) state_next = ST_LK_OUT;
        else state_next = ST_LK_LAST;
      end
      ST_LK_LAST: begin
        ram_raddr  = slot(oldest, '0);
        state_next = (q_reg > rd.ts) ? ST_LK_OUT : ST_LK_FIRST;
      end
      ST_LK_FIRST: begin
        a_next     = rd;
        widx_next  = CW'(1);
        ram_raddr  = slot(oldest, CW'(1));
        state_next = (q_reg < rd.ts) ? ST_LK_OUT : ST_LK_WALK;
      end
      ST_LK_WALK: begin
        // a_reg holds entry widx-1, rd holds entry widx
        b_next = rd;
        if (q_reg >= a_reg.ts && q_reg <= rd.ts) begin
          state_next = ST_LK_GAP;
        end else begin
          a_next = rd;
          if (widx == entry_count - CW'(1)) begin
            state_next = ST_LK_OUT;
          end else begin
            widx_next = widx + CW'(1);
            ram_raddr = slot(oldest, widx + CW'(1));
          end
        end
      end
      ST_LK_GAP: begin
        gap_out_next = (gap_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : gap_full[31:0];
        gap_next     = gap_full[29:0];
        off_next     = 30'(q_reg - a_reg.ts);
        if (gap_full > {34'd0, gap_limit}) begin
          state_next = ST_LK_OUT;
        end else begin
          found_next = 1'b1;
          if (gap_full == 64'd0) begin
            rate_next  = '{b_reg.roll, b_reg.pitch, b_reg.yaw};
            state_next = ST_LK_OUT;
          end else begin
            axis_next  = 2'd0;
            state_next = ST_MUL;
          end
        end
      end
      ST_LK_FIN: begin
        rate_next[axis] = neg_reg ? a_rate - dvd[31:0] : a_rate + dvd[31:0];
        if (axis == 2'd2) begin
          state_next = ST_LK_OUT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = ST_MUL;
        end
      end
      ST_LK_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tuser_next  = found_reg;
          m_tdata_next  = {gap_out, rate_reg[2], rate_reg[1], rate_reg[0]};
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      oldest      <= '0;
      prev_ok     <= 1'b0;
      prev_time   <= '0;
      prev_ang    <= '{3{32'd0}};
      m_tvalid    <= 1'b0;
      lat_off     <= '0;
      max_gap     <= MAX_GAP_RESET;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      oldest      <= oldest_next;
      prev_ok     <= prev_ok_next;
      prev_time   <= prev_time_next;
      prev_ang    <= prev_ang_next;
      m_tvalid    <= m_tvalid_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_LATENCY: lat_off <= cfg_data;
          CFG_MAX_GAP: max_gap <= cfg_data[29:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    is_lk     <= is_lk_next;
    axis      <= axis_next;
    wcnt      <= wcnt_next;
    dcnt      <= dcnt_next;
    t_reg     <= t_next;
    q_reg     <= q_next;
    cur_ang   <= cur_ang_next;
    dt_reg    <= dt_next;
    d_reg     <= d_next;
    neg_reg   <= neg_next;
    prod_reg  <= prod_next;
    dvd       <= dvd_next;
    rem       <= rem_next;
    div_reg   <= div_next;
    half_reg  <= half_next;
    rate_reg  <= rate_next;
    found_reg <= found_next;
    gap_out   <= gap_out_next;
    gap_reg   <= gap_next;
    off_reg   <= off_next;
    widx      <= widx_next;
    a_reg     <= a_next;
    b_reg     <= b_next;
    m_tdata   <= m_tdata_next;
    m_tuser   <= m_tuser_next;
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, entry_count <= CW'(HISTORY_DEPTH))
  `ASSERT_ALWAYS(a_oldest_range, clk, rst, oldest <= AW'(HISTORY_DEPTH - 1))
  `ASSERT_IMPL(a_lookup_busy, clk, rst, s_tvalid && s_tready && s_tuser == FUNC_LOOKUP, !s_tready)

endmodule
